[rtl/psqe_pkg.sv]
// Shared constants and helpers for the polyline stroke quad expander.
// No dependencies.
`default_nettype none
package psqe_pkg;

    localparam int unsigned COORD_W = 24;
    localparam int unsigned U_W     = 24;
    localparam int unsigned CNT_W   = 16;
    localparam int unsigned LEN_W   = 32;

    localparam logic [49:0] MIN_LEN_SQ     = 50'd16384;
    localparam logic [23:0] ONE_PX_Q8      = 24'd256;
    localparam logic [23:0] DEFAULT_REPEAT = 24'd65536;
    localparam logic [23:0] U_MAX          = 24'hFFFFFF;

    localparam logic REG_HALF_WIDTH    = 1'b0;
    localparam logic REG_REPEAT_LENGTH = 1'b1;

    function automatic logic [23:0] sat24(input logic signed [25:0] v);
        logic [23:0] r;
        if (v > 26'sd8388607)
            r = 24'h7FFFFF;
        else if (v < -26'sd8388608)
            r = 24'h800000;
        else
            r = v[23:0];
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/polyline_stroke_quad_expander.sv]
// Polyline stroke quad expander top level: sequencer with one shared multiplier,
// a bit-serial square root and a bit-serial restoring divider. Uses psqe_pkg.
//
// Usage:
//   s_* channel: one polyline point per request. s_tdata = {point_y, point_x},
//   s_tuser = line_start. A line_start point (or the first point after reset)
//   only stores the point and clears the cursor and segment counter.
//   m_* channel: one quad request per emitted segment, 288-bit tdata.
//   cfg_we/cfg_index/cfg_data write half_width (0) or repeat_length (1).
// Sequencing:
//   Line start points are taken in the idle state. Short segments or zero half width end after the length check.
//   Emitted segment: passes through the 25-step square root, two 17-step offset
//   divisions and up to two 24-step texture divisions, all one bit per cycle.
//   One point is in work at a time; a new point is taken as soon as the
//   previous result sits in the output register.
// Reset: asynchronous, clears control state and restores register defaults.
// Stall: a held output keeps its request; a finished quad waits in the final
//   step until the output register frees up, and no point is taken meanwhile.
`default_nettype none
module polyline_stroke_quad_expander (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [47:0]  s_tdata,   // point_x[23:0], point_y[47:24]
    input  wire logic         s_tuser,   // line_start
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // corner0_x, corner0_y, corner1_x, corner1_y, corner2_x, corner2_y,
    // corner3_x, corner3_y, tex_u_start, tex_u_end (24 each from bit 0),
    // emitted count[255:240], total_length[287:256]
    output logic [287:0]      m_tdata,
    input  wire logic         cfg_we,
    input  wire logic         cfg_index,
    input  wire logic [23:0]  cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_SQX, S_SQY, S_CHK, S_SQRT, S_MX, S_LX, S_DX,
        S_MY, S_LY, S_DY, S_LU0, S_DU0, S_LU1, S_DU1, S_OUT
    } state_t;

    state_t        state_reg;
    logic [15:0]   hw_reg;
    logic [23:0]   rep_reg;
    logic [23:0]   prev_x_reg, prev_y_reg, ax_reg, ay_reg, bx_reg, by_reg;
    logic          have_prev_reg;
    logic [31:0]   cursor_reg, cur1_reg;
    logic [15:0]   segs_reg;
    logic [24:0]   dx_reg, dy_reg;
    logic [49:0]   sq_reg;
    logic [49:0]   rad_reg;
    logic [24:0]   root_reg;
    logic [25:0]   srem_reg;
    logic [39:0]   mp_reg;
    logic [47:0]   dnum_reg;
    logic [25:0]   drem_reg, dden_reg;
    logic [23:0]   quo_reg;
    logic [4:0]    cnt_reg;
    logic signed [17:0] nx_reg, ny_reg;
    logic [23:0]   u0_reg;
    logic          m_tvalid_reg;
    logic [287:0]  m_tdata_reg;

    logic [24:0]   adx, ady, mul_a, mul_b;
    logic [49:0]   prod;
    logic [27:0]   sq_t;
    logic [26:0]   sq_trial;
    logic          sq_ge;
    logic [26:0]   dv_t;
    logic          dv_ge;
    logic [23:0]   quo_next;
    logic [41:0]   n42;
    logic [23:0]   rep_eff;
    logic [32:0]   cur_sum;
    logic signed [17:0] q_pos, q_neg;
    logic [24:0]   pdx, pdy;
    logic signed [25:0] ax_s, ay_s, bx_s, by_s, nx_s, ny_s;
    logic          out_load;

    assign adx = dx_reg[24] ? 25'(-dx_reg) : dx_reg;
    assign ady = dy_reg[24] ? 25'(-dy_reg) : dy_reg;

    always_comb
    begin
        mul_a = adx;
        mul_b = adx;
        case (state_reg)
            S_SQY:
            begin
                mul_a = ady;
                mul_b = ady;
            end
            S_MX:
            begin
                mul_a = ady;
                mul_b = {9'd0, hw_reg};
            end
            S_MY:
            begin
                mul_a = adx;
                mul_b = {9'd0, hw_reg};
            end
            default:
            begin
                mul_a = adx;
                mul_b = adx;
            end
        endcase
    end

    assign prod     = mul_a * mul_b;
    assign sq_t     = {srem_reg, rad_reg[49:48]};
    assign sq_trial = {root_reg, 2'b01};
    assign sq_ge    = sq_t >= {1'b0, sq_trial};
    assign dv_t     = {drem_reg, dnum_reg[47]};
    assign dv_ge    = dv_t >= {1'b0, dden_reg};
    assign quo_next = {quo_reg[22:0], dv_ge};
    assign n42      = {1'b0, mp_reg, 1'b0} + {17'd0, root_reg};
    assign rep_eff  = (rep_reg > psqe_pkg::ONE_PX_Q8) ? rep_reg : psqe_pkg::DEFAULT_REPEAT;
    assign cur_sum  = {1'b0, cursor_reg} + {8'd0, root_reg};
    assign q_pos    = $signed({1'b0, quo_next[16:0]});
    assign q_neg    = -q_pos;
    assign pdx      = 25'(s_tdata[23:0]);
    assign pdy      = 25'(s_tdata[47:24]);
    assign ax_s     = $signed({{2{ax_reg[23]}}, ax_reg});
    assign ay_s     = $signed({{2{ay_reg[23]}}, ay_reg});
    assign bx_s     = $signed({{2{bx_reg[23]}}, bx_reg});
    assign by_s     = $signed({{2{by_reg[23]}}, by_reg});
    assign nx_s     = $signed({{8{nx_reg[17]}}, nx_reg});
    assign ny_s     = $signed({{8{ny_reg[17]}}, ny_reg});
    assign out_load = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            hw_reg        <= 16'd768;
            rep_reg       <= psqe_pkg::DEFAULT_REPEAT;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            have_prev_reg <= 1'b0;
            cursor_reg    <= '0;
            segs_reg      <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    psqe_pkg::REG_HALF_WIDTH:    hw_reg  <= cfg_data[15:0];
                    psqe_pkg::REG_REPEAT_LENGTH: rep_reg <= cfg_data;
                    default:                     hw_reg  <= hw_reg;
                endcase
            end
            if (m_tvalid_reg && m_tready && !out_load)
                m_tvalid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        prev_x_reg    <= s_tdata[23:0];
                        prev_y_reg    <= s_tdata[47:24];
                        have_prev_reg <= 1'b1;
                        if (s_tuser || !have_prev_reg)
                        begin
                            cursor_reg <= '0;
                            segs_reg   <= '0;
                        end
                        else
                        begin
                            ax_reg    <= prev_x_reg;
                            ay_reg    <= prev_y_reg;
                            bx_reg    <= s_tdata[23:0];
                            by_reg    <= s_tdata[47:24];
                            dx_reg    <= 25'({pdx[23], pdx[23:0]} -
                                             {prev_x_reg[23], prev_x_reg});
                            dy_reg    <= 25'({pdy[23], pdy[23:0]} -
                                             {prev_y_reg[23], prev_y_reg});
                            state_reg <= S_SQX;
                        end
                    end
                end
                S_SQX:
                begin
                    sq_reg    <= prod;
                    state_reg <= S_SQY;
                end
                S_SQY:
                begin
                    sq_reg    <= sq_reg + prod;
                    state_reg <= S_CHK;
                end
                S_CHK:
                begin
                    if (sq_reg < psqe_pkg::MIN_LEN_SQ || hw_reg == 16'd0)
                        state_reg <= S_IDLE;
                    else
                    begin
                        rad_reg   <= sq_reg;
                        root_reg  <= '0;
                        srem_reg  <= '0;
                        cnt_reg   <= 5'd25;
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    rad_reg  <= {rad_reg[47:0], 2'b00};
                    srem_reg <= sq_ge ? 26'(sq_t - {1'b0, sq_trial}) : sq_t[25:0];
                    root_reg <= {root_reg[23:0], sq_ge};
                    cnt_reg  <= cnt_reg - 5'd1;
                    if (cnt_reg == 5'd1)
                        state_reg <= S_MX;
                end
                S_MX:
                begin
                    mp_reg    <= prod[39:0];
                    cur1_reg  <= cur_sum[32] ? 32'hFFFFFFFF : cur_sum[31:0];
                    state_reg <= S_LX;
                end
                S_LX, S_LY:
                begin
                    drem_reg  <= {1'b0, n42[41:17]};
                    dnum_reg  <= {n42[16:0], 31'd0};
                    dden_reg  <= {root_reg, 1'b0};
                    quo_reg   <= '0;
                    cnt_reg   <= 5'd17;
                    state_reg <= (state_reg == S_LX) ? S_DX : S_DY;
                end
                S_DX, S_DY, S_DU0, S_DU1:
                begin
                    drem_reg <= dv_ge ? 26'(dv_t - {1'b0, dden_reg}) : dv_t[25:0];
                    dnum_reg <= {dnum_reg[46:0], 1'b0};
                    quo_reg  <= quo_next;
                    cnt_reg  <= cnt_reg - 5'd1;
                    if (cnt_reg == 5'd1)
                    begin
                        case (state_reg)
                            S_DX:
                            begin
                                nx_reg    <= dy_reg[24] || dy_reg == '0 ? q_pos : q_neg;
                                state_reg <= S_MY;
                            end
                            S_DY:
                            begin
                                ny_reg    <= dx_reg[24] ? q_neg : q_pos;
                                state_reg <= S_LU0;
                            end
                            S_DU0:
                            begin
                                u0_reg    <= quo_next;
                                state_reg <= S_LU1;
                            end
                            default:
                            begin
                                state_reg <= S_OUT;
                            end
                        endcase
                    end
                end
                S_MY:
                begin
                    mp_reg    <= prod[39:0];
                    state_reg <= S_LY;
                end
                S_LU0, S_LU1:
                begin
                    if (((state_reg == S_LU0) ? cursor_reg[31:8] : cur1_reg[31:8])
                        >= rep_eff)
                    begin
                        if (state_reg == S_LU0)
                        begin
                            u0_reg    <= psqe_pkg::U_MAX;
                            state_reg <= S_LU1;
                        end
                        else
                        begin
                            quo_reg   <= psqe_pkg::U_MAX;
                            state_reg <= S_OUT;
                        end
                    end
                    else
                    begin
                        drem_reg  <= {2'b00, (state_reg == S_LU0) ? cursor_reg[31:8]
                                                                  : cur1_reg[31:8]};
                        dnum_reg  <= {(state_reg == S_LU0) ? cursor_reg[7:0]
                                                           : cur1_reg[7:0], 40'd0};
                        dden_reg  <= {2'b00, rep_eff};
                        quo_reg   <= '0;
                        cnt_reg   <= 5'd24;
                        state_reg <= (state_reg == S_LU0) ? S_DU0 : S_DU1;
                    end
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {cur1_reg,
                                         (segs_reg == 16'hFFFF) ? segs_reg : segs_reg + 16'd1,
                                         quo_reg, u0_reg,
                                         psqe_pkg::sat24(ay_s - ny_s),
                                         psqe_pkg::sat24(ax_s - nx_s),
                                         psqe_pkg::sat24(by_s - ny_s),
                                         psqe_pkg::sat24(bx_s - nx_s),
                                         psqe_pkg::sat24(by_s + ny_s),
                                         psqe_pkg::sat24(bx_s + nx_s),
                                         psqe_pkg::sat24(ay_s + ny_s),
                                         psqe_pkg::sat24(ax_s + nx_s)};
                        cursor_reg   <= cur1_reg;
                        if (segs_reg != 16'hFFFF)
                            segs_reg <= segs_reg + 16'd1;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire
